>>> rtl/core/rle_pkg.sv
// Shared types, constants and helpers for the RLE byte stream decoder.
package rle_pkg;

  localparam int OUT_LANES = 4;
  localparam int LANE_W    = 8;
  localparam int DATA_W    = 32;
  localparam int DATA_LANES = (OUT_LANES < DATA_W / LANE_W) ? OUT_LANES : DATA_W / LANE_W;
  localparam int CNT_W     = 4;
  localparam int SIZE_W    = 24;
  localparam int TOK_W     = 8;

  localparam int FLAG_RUN_BIT = 7;
  localparam logic [TOK_W-1:0] REP_BIAS  = TOK_W'(3);
  localparam logic [TOK_W-1:0] LIT_BIAS  = TOK_W'(1);
  localparam logic [TOK_W-1:0] LANES_TOK = TOK_W'(OUT_LANES);

  typedef struct packed {
    logic [7:0] in_byte;
    logic       stream_start;
  } in_word_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_bytes;
    logic [2:0]        byte_count;
    logic              last_of_input;
    logic              stream_done;
  } out_word_t;

  typedef enum logic [8:0] {
    ST_HDR0 = 9'b000000001,
    ST_HDR1 = 9'b000000010,
    ST_HDR2 = 9'b000000100,
    ST_HDR3 = 9'b000001000,
    ST_FLAG = 9'b000010000,
    ST_LIT  = 9'b000100000,
    ST_REPV = 9'b001000000,
    ST_RUN  = 9'b010000000,
    ST_DONE = 9'b100000000
  } phase_t;

  // replicate a byte into the low cnt lanes, upper lanes zero
  function automatic logic [DATA_W-1:0] fill_lanes(input logic [7:0] b,
                                                   input logic [CNT_W-1:0] cnt);
    logic [DATA_W-1:0] d;
    d = '0;
    for (int i = 0; i < DATA_LANES; i++) begin
      if (CNT_W'(i) < cnt) begin
        d[i*LANE_W +: LANE_W] = b;
      end
    end
    return d;
  endfunction

endpackage

>>> rtl/core/rle_byte_stream_decoder_top.sv
// RLE byte stream decoder: header parse, literal pass-through, packed repeat runs.
// Header and flag words update the sequencer state; a literal result sits in
// the output register the cycle after its input word is accepted.
// A repeat value word sets up the run, then results follow one packed word per
// cycle while the output is free, as the shared subtractor steps the run count;
// input is stalled for the whole run, and output back-pressure stretches it.
// Reset (rst_n low, synchronous) returns to header byte zero and empties the output.
module rle_byte_stream_decoder_top
  import rle_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_data
);

  // sequencer state
  phase_t              phase_r, phase_nxt;
  logic [SIZE_W-1:0]   bytes_rem_r, bytes_rem_nxt;
  logic [TOK_W-1:0]    tok_left_r, tok_left_nxt;
  // repeat run in progress
  logic [TOK_W-1:0]    run_left_r, run_left_nxt;
  logic [7:0]          run_byte_r, run_byte_nxt;
  logic                run_fin_r, run_fin_nxt;
  // output register
  logic                out_valid_r, out_valid_nxt;
  out_word_t           out_data_r, out_data_nxt;

  logic                out_free;
  logic                accept;
  phase_t              eff_phase;
  phase_t              sel_phase;
  logic [TOK_W-1:0]    run_n;
  logic [TOK_W-1:0]    chunk;
  // the one shared subtractor
  logic [SIZE_W-1:0]   sub_a, sub_b, sub_y;
  logic [SIZE_W-1:0]   hdr_size;

  assign out_free  = ~out_valid_r | ~out_stall;
  assign in_stall  = (phase_r == ST_RUN) | ~out_free;
  assign accept    = in_valid & ~in_stall;
  assign eff_phase = in_data.stream_start ? ST_HDR0 : phase_r;
  assign sel_phase = (phase_r == ST_RUN) ? ST_RUN : eff_phase;

  // run length cut to what is left of the stream
  assign run_n = ({{(SIZE_W-TOK_W){1'b0}}, tok_left_r} > bytes_rem_r) ?
                 bytes_rem_r[TOK_W-1:0] : tok_left_r;
  assign chunk = (run_left_r > LANES_TOK) ? LANES_TOK : run_left_r;

  always_comb begin
    sub_a = '0;
    sub_b = '0;
    case (sel_phase)
      ST_LIT: begin
        sub_a = bytes_rem_r;
        sub_b = SIZE_W'(1);
      end
      ST_REPV: begin
        sub_a = bytes_rem_r;
        sub_b = {{(SIZE_W-TOK_W){1'b0}}, run_n};
      end
      ST_RUN: begin
        sub_a = {{(SIZE_W-TOK_W){1'b0}}, run_left_r};
        sub_b = {{(SIZE_W-TOK_W){1'b0}}, chunk};
      end
      default: begin
        sub_a = '0;
        sub_b = '0;
      end
    endcase
  end

  assign sub_y    = sub_a - sub_b;
  assign hdr_size = bytes_rem_r | {in_data.in_byte, 16'h0000};

  always_comb begin
    phase_nxt     = phase_r;
    bytes_rem_nxt = bytes_rem_r;
    tok_left_nxt  = tok_left_r;
    run_left_nxt  = run_left_r;
    run_byte_nxt  = run_byte_r;
    run_fin_nxt   = run_fin_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;

    if (accept) begin
      case (eff_phase)
        ST_HDR0: begin
          bytes_rem_nxt = '0;
          tok_left_nxt  = '0;
          phase_nxt     = ST_HDR1;
        end
        ST_HDR1: begin
          bytes_rem_nxt = {16'h0000, in_data.in_byte};
          phase_nxt     = ST_HDR2;
        end
        ST_HDR2: begin
          bytes_rem_nxt = bytes_rem_r | {8'h00, in_data.in_byte, 8'h00};
          phase_nxt     = ST_HDR3;
        end
        ST_HDR3: begin
          bytes_rem_nxt = hdr_size;
          phase_nxt     = (hdr_size == '0) ? ST_DONE : ST_FLAG;
        end
        ST_FLAG: begin
          if (in_data.in_byte[FLAG_RUN_BIT]) begin
            tok_left_nxt = {1'b0, in_data.in_byte[6:0]} + REP_BIAS;
            phase_nxt    = ST_REPV;
          end else begin
            tok_left_nxt = {1'b0, in_data.in_byte[6:0]} + LIT_BIAS;
            phase_nxt    = ST_LIT;
          end
        end
        ST_LIT: begin
          bytes_rem_nxt              = sub_y;
          tok_left_nxt               = tok_left_r - LIT_BIAS;
          out_valid_nxt              = 1'b1;
          out_data_nxt.out_bytes     = {{(DATA_W-8){1'b0}}, in_data.in_byte};
          out_data_nxt.byte_count    = 3'd1;
          out_data_nxt.last_of_input = 1'b1;
          out_data_nxt.stream_done   = (sub_y == '0);
          if (sub_y == '0) begin
            phase_nxt = ST_DONE;
          end else if (tok_left_r == LIT_BIAS) begin
            phase_nxt = ST_FLAG;
          end
        end
        ST_REPV: begin
          bytes_rem_nxt = sub_y;
          tok_left_nxt  = '0;
          run_left_nxt  = run_n;
          run_byte_nxt  = in_data.in_byte;
          run_fin_nxt   = (sub_y == '0);
          if (run_n != '0) begin
            phase_nxt = ST_RUN;
          end else begin
            phase_nxt = (sub_y == '0) ? ST_DONE : ST_FLAG;
          end
        end
        default: begin
          phase_nxt = phase_r;
        end
      endcase
    end

    // drain a repeat run, one packed word per free output slot
    if (phase_r == ST_RUN && out_free) begin
      out_valid_nxt              = 1'b1;
      out_data_nxt.out_bytes     = fill_lanes(run_byte_r, chunk[CNT_W-1:0]);
      out_data_nxt.byte_count    = chunk[2:0];
      out_data_nxt.last_of_input = (sub_y == '0);
      out_data_nxt.stream_done   = (sub_y == '0) & run_fin_r;
      run_left_nxt               = sub_y[TOK_W-1:0];
      if (sub_y == '0) begin
        phase_nxt = run_fin_r ? ST_DONE : ST_FLAG;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= ST_HDR0;
      bytes_rem_r <= '0;
      tok_left_r  <= '0;
      run_left_r  <= '0;
      run_fin_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      bytes_rem_r <= bytes_rem_nxt;
      tok_left_r  <= tok_left_nxt;
      run_left_r  <= run_left_nxt;
      run_fin_r   <= run_fin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    run_byte_r <= run_byte_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a run in flight always has bytes left to send
  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == ST_RUN) |-> (run_left_r != '0))
    else $error("repeat run active with nothing left");

  // the final byte of a stream closes its input word
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.stream_done) |-> out_data_r.last_of_input)
    else $error("stream_done without last_of_input");

  // a word finishing a stream leaves the sequencer in the done state
  a_done_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_nxt && out_data_nxt.stream_done && !(out_valid_r && out_stall))
      |=> (phase_r == ST_DONE))
    else $error("stream finished but sequencer not done");

endmodule
